/* src/sfq_pkg.sv */
// Shared types and constants of the searchable FIFO queue.
package sfq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int VALUE_W     = 32;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int CMD_W       = 2;
   localparam int STATUS_W    = 2;
   localparam int MATCH_W     = 5;
   localparam int OCC_W       = 5;

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [CNT_W-1:0]          cnt_type;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_SEARCH = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   typedef enum logic {
      ST_IDLE,
      ST_SEARCH
   } state_type;

   // Search token handed from cell to cell.
   typedef struct packed {
      logic      active;
      value_type key;
      cnt_type   hits;
   } srch_type;

endpackage

/* src/sfq_cell.sv */
// One queue cell: holds an entry, shifts toward the head, and counts a search match.
module sfq_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              shift,
   input  logic              write,
   input  logic              occupied,
   input  sfq_pkg::value_type wr_value,
   input  sfq_pkg::value_type nbr_value,
   output sfq_pkg::value_type entry,
   input  sfq_pkg::srch_type  srch_in,
   output sfq_pkg::srch_type  srch_out
);
   import sfq_pkg::*;

   value_type entry_ff;
   value_type entry_in;
   logic      act_ff;
   value_type key_ff;
   cnt_type   hits_ff;
   cnt_type   hits_in;
   logic      hit;

   always_comb begin
      entry_in = entry_ff;
      if (write) begin
         entry_in = wr_value;
      end else if (shift) begin
         entry_in = nbr_value;
      end
      hit     = occupied && (entry_ff == srch_in.key);
      hits_in = srch_in.hits + CNT_W'(hit);
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      key_ff   <= srch_in.key;
      hits_ff  <= hits_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= 1'b0;
      end else begin
         act_ff <= srch_in.active;
      end
   end

   assign entry           = entry_ff;
   assign srch_out.active = act_ff;
   assign srch_out.key    = key_ff;
   assign srch_out.hits   = hits_ff;

endmodule

/* src/searchable_fifo_queue_unit.sv */
// Searchable FIFO queue: top level with command control and the cell row.
//
// A first-in first-out queue of QUEUE_DEPTH signed 32-bit entries kept in a row
// of cells, the head always in cell 0. Each request carries a command: insert
// at the tail, remove the head, or search, which counts the held entries equal
// to the request value. Every request yields exactly one response with status
// (ok, empty, full), match count, occupancy after the command and the removed
// value (0 unless a remove succeeded). An insert into a full queue is dropped
// and flagged full; remove or search on an empty queue is flagged empty; the
// unused command code does nothing and reports the current occupancy.
// Timing: insert, remove, the unused code and an empty search load the response
// register at the same edge that takes the request, and it is shown in the next
// cycle. A search on a non-empty queue sends the key down the cell row one cell
// per cycle, each cell adding its own match to the count; the response is loaded
// once the key has left the last cell, and the queue takes no request until that
// response is loaded. A request is taken whenever the block is not searching and
// the response register is free or being emptied in the same cycle.
module searchable_fifo_queue_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [sfq_pkg::CMD_W-1:0]       req_cmd,
   input  logic signed [sfq_pkg::VALUE_W-1:0] req_value,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [sfq_pkg::STATUS_W-1:0]    rsp_status,
   output logic [sfq_pkg::MATCH_W-1:0]     rsp_match_count,
   output logic [sfq_pkg::OCC_W-1:0]       rsp_occupancy,
   output logic signed [sfq_pkg::VALUE_W-1:0] rsp_removed_value
);
   import sfq_pkg::*;

   state_type  state_ff, state_in;
   cnt_type    count_ff, count_in;

   // response register
   logic       rsp_valid_ff, rsp_valid_in;
   status_type status_ff, status_in;
   cnt_type    match_ff, match_in;
   cnt_type    occ_ff, occ_in;
   value_type  removed_ff, removed_in;

   // cell row
   value_type  entry_q [QUEUE_DEPTH];
   srch_type   srch_link [QUEUE_DEPTH+1];
   srch_type   srch_head;
   logic       shift_en;
   logic       insert_en;
   logic       accept;
   logic       is_empty;
   logic       is_full;
   cmd_type    cmd_sel;

   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign cmd_sel   = cmd_type'(req_cmd);
   assign is_empty  = (count_ff == '0);
   assign is_full   = (count_ff == CNT_W'(QUEUE_DEPTH));

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      status_in    = status_ff;
      match_in     = match_ff;
      occ_in       = occ_ff;
      removed_in   = removed_ff;
      shift_en     = 1'b0;
      insert_en    = 1'b0;
      srch_head.active = 1'b0;
      srch_head.key    = req_value;
      srch_head.hits   = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               status_in    = STAT_OK;
               match_in     = '0;
               removed_in   = '0;
               unique case (cmd_sel)
                  CMD_INSERT: begin
                     if (is_full) begin
                        status_in = STAT_FULL;
                     end else begin
                        insert_en = 1'b1;
                        count_in  = count_ff + CNT_W'(1);
                     end
                  end
                  CMD_REMOVE: begin
                     if (is_empty) begin
                        status_in = STAT_EMPTY;
                     end else begin
                        shift_en   = 1'b1;
                        removed_in = entry_q[0];
                        count_in   = count_ff - CNT_W'(1);
                     end
                  end
                  CMD_SEARCH: begin
                     if (is_empty) begin
                        status_in = STAT_EMPTY;
                     end else begin
                        // result comes back from the end of the row
                        rsp_valid_in     = 1'b0;
                        srch_head.active = 1'b1;
                        state_in         = ST_SEARCH;
                     end
                  end
                  default: begin
                     // unused code: no operation
                  end
               endcase
               occ_in = count_in;
            end
         end
         ST_SEARCH: begin
            if (srch_link[QUEUE_DEPTH].active) begin
               rsp_valid_in = 1'b1;
               status_in    = STAT_OK;
               match_in     = srch_link[QUEUE_DEPTH].hits;
               occ_in       = count_ff;
               removed_in   = '0;
               state_in     = ST_IDLE;
            end
         end
      endcase
   end

   assign srch_link[0] = srch_head;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff  <= status_in;
      match_ff   <= match_in;
      occ_ff     <= occ_in;
      removed_ff <= removed_in;
   end

   // Cell i holds the i-th entry from the head. Insert writes the cell at the
   // current count; remove shifts every cell one place toward the head.
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      value_type nbr;
      logic      occupied;
      logic      write;

      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign nbr = entry_q[i];
      end else begin : g_mid
         assign nbr = entry_q[i+1];
      end

      assign occupied = (CNT_W'(i) < count_ff);
      assign write    = insert_en && (count_ff == CNT_W'(i));

      sfq_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift     (shift_en),
         .write     (write),
         .occupied  (occupied),
         .wr_value  (req_value),
         .nbr_value (nbr),
         .entry     (entry_q[i]),
         .srch_in   (srch_link[i]),
         .srch_out  (srch_link[i+1])
      );
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_match_count   = MATCH_W'(match_ff);
   assign rsp_occupancy     = OCC_W'(occ_ff);
   assign rsp_removed_value = removed_ff;

endmodule

/* src/sfq_checker.sv */
// Port-level checks of the searchable FIFO queue, bound to the top level.
module sfq_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic [sfq_pkg::STATUS_W-1:0]    rsp_status,
   input logic [sfq_pkg::MATCH_W-1:0]     rsp_match_count,
   input logic [sfq_pkg::OCC_W-1:0]       rsp_occupancy,
   input logic signed [sfq_pkg::VALUE_W-1:0] rsp_removed_value
);
   import sfq_pkg::*;

   a_occ_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_occupancy <= OCC_W'(QUEUE_DEPTH)))
      else $error("occupancy beyond queue depth");

   a_full_means_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STAT_FULL)) |-> (rsp_occupancy == OCC_W'(QUEUE_DEPTH)))
      else $error("full status with room left");

   a_empty_means_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STAT_EMPTY)) |->
         ((rsp_occupancy == '0) && (rsp_match_count == '0) && (rsp_removed_value == '0)))
      else $error("empty status with entries or data");

   a_match_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_match_count <= rsp_occupancy))
      else $error("more matches than entries");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_status == STAT_OK) || (rsp_status == STAT_EMPTY) ||
                     (rsp_status == STAT_FULL)))
      else $error("unknown status code");

endmodule

bind searchable_fifo_queue_unit sfq_checker u_sfq_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_status        (rsp_status),
   .rsp_match_count   (rsp_match_count),
   .rsp_occupancy     (rsp_occupancy),
   .rsp_removed_value (rsp_removed_value)
);

/* dv/sfq_queue_checker.sv */
// Checker for the searchable FIFO queue: queue predictor and response compare.
module sfq_queue_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic [sfq_pkg::CMD_W-1:0]         req_cmd,
   input  sfq_pkg::value_type                req_value,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [sfq_pkg::STATUS_W-1:0]      rsp_status,
   input  logic [sfq_pkg::MATCH_W-1:0]       rsp_match_count,
   input  logic [sfq_pkg::OCC_W-1:0]         rsp_occupancy,
   input  sfq_pkg::value_type                rsp_removed_value,
   output int                                mismatch_count,
   output int                                expected_count,
   output int                                full_flags,
   output int                                empty_flags,
   output int                                deepest_match
);

   timeunit 1ns;
   timeprecision 1ps;

   import sfq_pkg::*;

   localparam int IDX_W = $clog2(QUEUE_DEPTH);

   typedef struct {
      status_type          status;
      logic [MATCH_W-1:0]  match_count;
      logic [OCC_W-1:0]    occupancy;
      value_type           removed_value;
   } queue_response_type;

   // Ring-buffer model of the queue contents.
   value_type       shadow_entries [QUEUE_DEPTH];
   logic [IDX_W-1:0] shadow_head;
   logic [IDX_W-1:0] shadow_tail;
   cnt_type         shadow_count;

   queue_response_type predicted_responses [$];

   initial begin
      mismatch_count = 0;
      expected_count = 0;
      full_flags     = 0;
      empty_flags    = 0;
      deepest_match  = 0;
   end

   function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
      return (idx == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : idx + 1'b1;
   endfunction

   task automatic apply_queue_command(input logic [CMD_W-1:0] cmd, input value_type value,
                                      output queue_response_type rsp);
      logic [IDX_W-1:0] idx;
      cnt_type          hits;
      begin
         rsp.status        = STAT_OK;
         rsp.match_count   = '0;
         rsp.removed_value = '0;
         hits              = '0;
         case (cmd)
            CMD_INSERT: begin
               if (shadow_count >= cnt_type'(QUEUE_DEPTH)) begin
                  rsp.status = STAT_FULL;
               end else begin
                  shadow_entries[shadow_tail] = value;
                  shadow_tail  = ring_next(shadow_tail);
                  shadow_count = shadow_count + 1'b1;
               end
            end
            CMD_REMOVE: begin
               if (shadow_count == '0) begin
                  rsp.status = STAT_EMPTY;
               end else begin
                  rsp.removed_value = shadow_entries[shadow_head];
                  shadow_head  = ring_next(shadow_head);
                  shadow_count = shadow_count - 1'b1;
               end
            end
            CMD_SEARCH: begin
               if (shadow_count == '0) begin
                  rsp.status = STAT_EMPTY;
               end else begin
                  idx = shadow_head;
                  for (int k = 0; k < int'(shadow_count); k++) begin
                     if (shadow_entries[idx] == value) hits = hits + 1'b1;
                     idx = ring_next(idx);
                  end
               end
            end
            default: begin
               // unused code: nothing changes
            end
         endcase
         rsp.match_count = MATCH_W'(hits);
         rsp.occupancy   = OCC_W'(shadow_count);
      end
   endtask

   always @(posedge clock) begin
      queue_response_type exp_rsp;
      queue_response_type new_rsp;
      if (reset) begin
         for (int i = 0; i < QUEUE_DEPTH; i++) shadow_entries[i] = '0;
         shadow_head  = '0;
         shadow_tail  = '0;
         shadow_count = '0;
         predicted_responses.delete();
      end else begin
         // response side first: a response never belongs to a request of the same edge
         if (rsp_valid && !rsp_stall) begin
            if (predicted_responses.size() == 0) begin
               $error("response with no request waiting");
               mismatch_count++;
            end else begin
               exp_rsp = predicted_responses.pop_front();
               if (rsp_status !== exp_rsp.status) begin
                  $error("status: expected %0d, got %0d", exp_rsp.status, rsp_status);
                  mismatch_count++;
               end
               if (rsp_match_count !== exp_rsp.match_count) begin
                  $error("match_count: expected %0d, got %0d",
                         exp_rsp.match_count, rsp_match_count);
                  mismatch_count++;
               end
               if (rsp_occupancy !== exp_rsp.occupancy) begin
                  $error("occupancy: expected %0d, got %0d",
                         exp_rsp.occupancy, rsp_occupancy);
                  mismatch_count++;
               end
               if (rsp_removed_value !== exp_rsp.removed_value) begin
                  $error("removed_value: expected %0d, got %0d",
                         exp_rsp.removed_value, rsp_removed_value);
                  mismatch_count++;
               end
               if (exp_rsp.status == STAT_FULL)  full_flags++;
               if (exp_rsp.status == STAT_EMPTY) empty_flags++;
               if (int'(exp_rsp.match_count) > deepest_match)
                  deepest_match = int'(exp_rsp.match_count);
            end
         end
         if (req_valid && !req_stall) begin
            apply_queue_command(req_cmd, req_value, new_rsp);
            predicted_responses.push_back(new_rsp);
         end
      end
      expected_count <= predicted_responses.size();
   end

endmodule

/* dv/tb_searchable_fifo_queue_unit.sv */
// Testbench top for the searchable FIFO queue: stimulus, flow control and verdict.
module tb_searchable_fifo_queue_unit;

   timeunit 1ns;
   timeprecision 1ps;

   import sfq_pkg::*;

   // Code 3 is not an enum member; the block must treat it as a no-op.
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   localparam int RANDOM_ITEMS   = 1525;
   localparam int PAUSE_AT       = 1100;  // sender drains the block here
   localparam int QUIET_FIRST    = 700;   // no idling on either side in this window
   localparam int QUIET_LAST     = 900;
   localparam int HOLD_AT        = 300;   // receiver hold-off starts after this many responses
   localparam int HOLD_LEN       = 150;
   localparam int IDLE_PCT       = 7;
   localparam int STALL_LIMIT    = 2000;  // cycles with no handshake at all
   localparam int SETTLE_CYCLES  = 2 * QUEUE_DEPTH + 4;

   localparam value_type VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
   localparam value_type VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

   typedef enum int {
      MODE_FILL,
      MODE_DRAIN,
      MODE_MIXED,
      MODE_FLOOD
   } traffic_mode_type;

   logic                    clock             = 1'b0;
   logic                    reset             = 1'b1;
   logic                    req_valid         = 1'b0;
   logic                    req_stall;
   logic [CMD_W-1:0]        req_cmd           = '0;
   value_type               req_value         = '0;
   logic                    rsp_valid;
   logic                    rsp_stall         = 1'b0;
   logic [STATUS_W-1:0]     rsp_status;
   logic [MATCH_W-1:0]      rsp_match_count;
   logic [OCC_W-1:0]        rsp_occupancy;
   value_type               rsp_removed_value;

   int mismatch_count;
   int expected_count;
   int full_flags;
   int empty_flags;
   int deepest_match;

   // Request tallies for the closing summary.
   int sent_total  = 0;
   int sent_insert = 0;
   int sent_remove = 0;
   int sent_search = 0;
   int sent_unused = 0;

   always #10 clock = ~clock;

   searchable_fifo_queue_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd           (req_cmd),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_match_count   (rsp_match_count),
      .rsp_occupancy     (rsp_occupancy),
      .rsp_removed_value (rsp_removed_value)
   );

   sfq_queue_checker queue_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd           (req_cmd),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_match_count   (rsp_match_count),
      .rsp_occupancy     (rsp_occupancy),
      .rsp_removed_value (rsp_removed_value),
      .mismatch_count    (mismatch_count),
      .expected_count    (expected_count),
      .full_flags        (full_flags),
      .empty_flags       (empty_flags),
      .deepest_match     (deepest_match)
   );

   // One of the four boundary values of a signed 32-bit field.
   function automatic value_type corner_value(input int sel);
      case (sel)
         0:       return VAL_MIN;
         1:       return VAL_MAX;
         2:       return '0;
         default: return '1;
      endcase
   endfunction

   // Seed value for the per-segment pool: corners, small numbers around zero,
   // or anything at all. Small pools make duplicates and thus search hits likely.
   function automatic value_type fresh_pool_value();
      case ($urandom_range(3))
         0:       return corner_value($urandom_range(3));
         1:       return value_type'($urandom_range(15)) - value_type'(8);
         default: return value_type'($urandom);
      endcase
   endfunction

   // Offer one request and hold it until the block takes it. Stall is read right
   // after the edge, so it is the value the block saw at that edge. A random
   // idle gap may come first, outside the quiet window.
   task automatic send_request(input logic [CMD_W-1:0] cmd, input value_type value);
      begin
         while (!(sent_total >= QUIET_FIRST && sent_total < QUIET_LAST) &&
                $urandom_range(99) < IDLE_PCT) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
         req_valid <= 1'b1;
         req_cmd   <= cmd;
         req_value <= value;
         @(posedge clock);
         while (req_stall) @(posedge clock);
         sent_total++;
         case (cmd)
            CMD_INSERT: sent_insert++;
            CMD_REMOVE: sent_remove++;
            CMD_SEARCH: sent_search++;
            default:    sent_unused++;
         endcase
      end
   endtask

   // Drop valid and wait until every outstanding request has been answered.
   // expected_count is registered in the checker, so the first edge after the
   // last handshake still shows the old value; hence the leading wait.
   task automatic wait_for_drain();
      begin
         req_valid <= 1'b0;
         @(posedge clock);
         while (expected_count != 0) @(posedge clock);
      end
   endtask

   // Receiver: random stalls, a quiet window, and one long hold-off after a
   // few hundred responses so the response register fills and the block
   // pushes back on requests.
   initial begin
      int taken;
      int hold_left;
      bit hold_done;
      taken     = 0;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) taken++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (!hold_done && taken >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_LEN - 1;
            rsp_stall <= 1'b1;
         end else if (taken >= QUIET_FIRST && taken < QUIET_LAST) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < IDLE_PCT);
         end
      end
   end

   // Watchdog: any cycle with a handshake on either side restarts the count.
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
      $display("tb_searchable_fifo_queue_unit failed");
      $finish;
   end

   // Main stimulus and verdict.
   initial begin
      traffic_mode_type mode;
      int               seg_left;
      int               roll;
      int               ins_pct;
      int               rem_pct;
      int               srch_pct;
      logic [CMD_W-1:0] cmd;
      value_type        value;
      value_type        value_pool [4];

      mode     = MODE_MIXED;
      seg_left = 0;
      for (int i = 0; i < 4; i++) value_pool[i] = '0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed part ----
      // empty queue: remove and search flag empty, unused code is a no-op
      send_request(CMD_REMOVE, VAL_MAX);
      send_request(CMD_SEARCH, '0);
      send_request(CMD_UNUSED, VAL_MIN);
      // fill to the brim: the four corners, then twelve copies of one value
      for (int i = 0; i < 4; i++) send_request(CMD_INSERT, corner_value(i));
      for (int i = 0; i < QUEUE_DEPTH - 4; i++) send_request(CMD_INSERT, value_type'(7));
      // insert into a full queue is dropped and flagged
      send_request(CMD_INSERT, value_type'(7));
      send_request(CMD_SEARCH, value_type'(7));
      send_request(CMD_SEARCH, VAL_MIN);
      send_request(CMD_UNUSED, '1);
      // remove gives back the oldest entry, then search the largest value
      send_request(CMD_REMOVE, '0);
      send_request(CMD_SEARCH, VAL_MAX);

      // ---- random part ----
      // Traffic comes in segments biased toward filling, draining, mixing or
      // flooding with a single value; the queue keeps crossing empty and full
      // and both ring indices wrap many times.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (seg_left == 0) begin
            mode     = traffic_mode_type'($urandom_range(3));
            seg_left = $urandom_range(10, 40);
            for (int i = 0; i < 4; i++) value_pool[i] = fresh_pool_value();
         end
         seg_left--;

         case (mode)
            MODE_FILL:  begin ins_pct = 60; rem_pct = 10; srch_pct = 25; end
            MODE_DRAIN: begin ins_pct = 10; rem_pct = 60; srch_pct = 25; end
            MODE_FLOOD: begin ins_pct = 70; rem_pct = 5;  srch_pct = 23; end
            default:    begin ins_pct = 33; rem_pct = 32; srch_pct = 30; end
         endcase
         roll = $urandom_range(99);
         if (roll < ins_pct)                           cmd = CMD_INSERT;
         else if (roll < ins_pct + rem_pct)            cmd = CMD_REMOVE;
         else if (roll < ins_pct + rem_pct + srch_pct) cmd = CMD_SEARCH;
         else                                          cmd = CMD_UNUSED;

         // Flood keeps one value so full-queue searches can count every entry.
         roll = $urandom_range(99);
         if (mode == MODE_FLOOD && (cmd == CMD_INSERT || roll < 70))
            value = value_pool[0];
         else if (roll < 60)
            value = value_pool[$urandom_range(3)];
         else if (roll < 75)
            value = corner_value($urandom_range(3));
         else
            value = value_type'($urandom);

         // sender holds off once until the block has answered everything
         if (n == PAUSE_AT) wait_for_drain();
         send_request(cmd, value);
      end

      // ---- wind down ----
      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_count != 0) begin
         $error("%0d responses never arrived", expected_count);
      end

      $display("covered %0d requests: %0d inserts, %0d removes, %0d searches, %0d unused",
               sent_total, sent_insert, sent_remove, sent_search, sent_unused);
      $display("full flags %0d, empty flags %0d, most matches in one search %0d",
               full_flags, empty_flags, deepest_match);
      if (mismatch_count == 0 && expected_count == 0) begin
         $display("tb_searchable_fifo_queue_unit passed");
      end else begin
         $display("tb_searchable_fifo_queue_unit failed");
      end
      $finish;
   end

endmodule
